// File: rtl/core/rbs_pkg.sv
package rbs_pkg;

  localparam int unsigned MAX_DIM_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned ONE_Q16         = 65536;
  // ceil(2^22 / 3), exact floor division by three for values below 2^21
  localparam logic [20:0] RECIP3          = 21'd1398102;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_EVAL = 2'd1,
    KIND_NULL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_MODE = 2'd2
  } reg_e;

  typedef struct packed {
    kind_e              kind;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic [16:0]        u;
    logic [16:0]        v;
  } entry_t;

  typedef struct packed {
    logic [4:0] rows;
    logic [4:0] cols;
    logic       rational;
  } cfg_t;

endpackage

// File: rtl/core/rbs_front.sv
module rbs_front import rbs_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  output logic               cfg_ready_o,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [3:0]         row_i,
  input  logic [3:0]         col_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] point_weight_i,
  input  logic [16:0]        u_param_i,
  input  logic [16:0]        v_param_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output entry_t             q_entry_o,
  output cfg_t               cfg_o
);

  localparam logic [16:0] ONE = 17'(ONE_Q16);

  logic [4:0] rows_q, cols_q;
  logic       mode_q;
  logic [4:0] rows_c, cols_c;
  logic       accept, load_ok, grid_short;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 5'd4;
      cols_q <= 5'd4;
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_ROWS: rows_q <= cfg_data_i;
        REG_COLS: cols_q <= cfg_data_i;
        REG_MODE: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // grids wider than the store act as the full store
  assign rows_c = (32'(rows_q) > MAX_DIM) ? 5'(MAX_DIM) : rows_q;
  assign cols_c = (32'(cols_q) > MAX_DIM) ? 5'(MAX_DIM) : cols_q;
  assign cfg_o  = '{rows: rows_c, cols: cols_c, rational: mode_q};

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign load_ok    = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
  assign grid_short = (rows_c < 5'd4) || (cols_c < 5'd4);

  // drop loads that fall outside the store
  assign q_push_o = accept && (operation_i || load_ok);

  always_comb begin
    q_entry_o.kind = !operation_i ? KIND_LOAD : (grid_short ? KIND_NULL : KIND_EVAL);
    q_entry_o.row  = row_i;
    q_entry_o.col  = col_i;
    q_entry_o.x    = point_x_i;
    q_entry_o.y    = point_y_i;
    q_entry_o.z    = point_z_i;
    q_entry_o.w    = point_weight_i;
    q_entry_o.u    = (u_param_i > ONE) ? ONE : u_param_i;
    q_entry_o.v    = (v_param_i > ONE) ? ONE : v_param_i;
  end

endmodule

// File: rtl/core/rbs_queue.sv
module rbs_queue import rbs_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          slot_q [DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (32'(cnt_q) == DEPTH);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: rtl/core/rbs_divider.sv
module rbs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               busy_o,
  output logic [31:0]        res_o
);

  logic        busy_q, neg_q;
  logic [6:0]  cnt_q;
  logic [63:0] ad_q, dq_q, rem_q, quo_q;
  logic [63:0] an_c, ad_c;
  logic [64:0] rem_n;

  assign an_c  = num_i[63] ? 64'd0 - num_i : num_i;
  assign ad_c  = den_i[63] ? 64'd0 - den_i : den_i;
  assign rem_n = {rem_q, dq_q[63]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == 7'd1) busy_q <= 1'b0;
    end
  end

  // one quotient bit per cycle, dividend pre-biased by half the divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[63] ^ den_i[63];
      ad_q  <= ad_c;
      dq_q  <= an_c + (ad_c >> 1);
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dq_q <= {dq_q[62:0], 1'b0};
      if (rem_n >= {1'b0, ad_q}) begin
        rem_q <= 64'(rem_n - {1'b0, ad_q});
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_n[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;

  always_comb begin
    if (neg_q) res_o = (quo_q > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - quo_q);
    else       res_o = (quo_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_q[31:0];
  end

endmodule

// File: rtl/core/rbs_back.sv
module rbs_back import rbs_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  input  entry_t             q_entry_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] surf_x_o,
  output logic signed [31:0] surf_y_o,
  output logic signed [31:0] surf_z_o,
  output logic               point_valid_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [16:0] ONE   = 17'(ONE_Q16);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_BASIS = 6'b000010,
    S_TAPS  = 6'b000100,
    S_CHECK = 6'b001000,
    S_DIV   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q;
  logic [2:0] bcnt_q;
  logic [4:0] tap_q;

  logic [127:0] mem_q [DEPTH];
  logic [127:0] rd_q;
  logic         mem_we;
  logic [AW-1:0] waddr, raddr;

  logic [16:0] u_q, v_q;

  // basis pipeline, index 0 is u (rows), 1 is v (cols)
  logic [16:0] g_c      [2];
  logic [4:0]  spans_c  [2];
  logic [21:0] scaled_c [2];
  logic [5:0]  sraw_c   [2];
  logic [4:0]  span_c   [2];
  logic [4:0]  span_q   [2];
  logic [16:0] t_q      [2];
  logic [16:0] tb_q     [2];
  logic [33:0] t2_q     [2];
  logic [33:0] m2_q     [2];
  logic [16:0] tc_q     [2];
  logic [33:0] t2c_q    [2];
  logic [50:0] t3_q     [2];
  logic [50:0] m3_q     [2];
  logic signed [52:0] n1_c [2];
  logic signed [52:0] n2_c [2];
  logic signed [52:0] t3e_c [2];
  logic signed [52:0] t2s_c [2];
  logic signed [52:0] t32_c [2];
  logic [18:0] n_q [2][4];
  logic [16:0] b_q [2][4];

  // tap pipeline
  logic        issue;
  logic [1:0]  ta, tc;
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        l1_q, l2_q, l3_q, l4_q;
  logic [32:0] prod_q;
  logic signed [31:0] wsel;
  logic signed [49:0] pa_q;
  logic [48:0]        pb_q;
  logic signed [31:0] c2_q [3];
  logic signed [31:0] c3_q [3];
  logic signed [65:0] vsum_c;
  logic signed [33:0] coeff_q, coeff4_q;
  logic signed [49:0] ph_q [3];
  logic signed [50:0] pl_q [3];
  logic signed [63:0] acc_q [3];
  logic signed [63:0] den_q;

  logic        div_start;
  logic [2:0]  div_busy;
  logic [31:0] div_res [3];

  logic               res_ok_q;
  logic signed [31:0] res_q [3];
  logic               out_valid_q, out_ok_q;
  logic signed [31:0] out_q [3];
  logic               emit_go;

  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i;
  assign mem_we    = q_pop_o && (q_entry_i.kind == KIND_LOAD);
  assign waddr     = AW'(32'(q_entry_i.row) * MAX_DIM + 32'(q_entry_i.col));
  assign issue     = (state_q == S_TAPS) && (tap_q < 5'd16);
  assign ta        = tap_q[3:2];
  assign tc        = tap_q[1:0];
  assign raddr     = AW'(32'(span_q[0] + 5'(ta)) * MAX_DIM + 32'(span_q[1] + 5'(tc)));
  assign div_start = (state_q == S_CHECK) && (den_q != '0);
  assign emit_go   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= {q_entry_i.x, q_entry_i.y, q_entry_i.z, q_entry_i.w};
    rd_q <= mem_q[raddr];
  end

  // span and local parameter
  always_comb begin
    for (int d = 0; d < 2; d++) begin
      g_c[d]      = (d == 0) ? u_q : v_q;
      spans_c[d]  = ((d == 0) ? cfg_i.rows : cfg_i.cols) - 5'd3;
      scaled_c[d] = 22'(g_c[d]) * 22'(spans_c[d]);
      sraw_c[d]   = scaled_c[d][21:16];
      span_c[d]   = (sraw_c[d] > {1'b0, spans_c[d] - 5'd1}) ? spans_c[d] - 5'd1
                                                             : sraw_c[d][4:0];
      t3e_c[d]    = $signed({2'b00, t3_q[d]});
      t2s_c[d]    = $signed({3'b000, t2c_q[d], 16'd0});
      t32_c[d]    = $signed({4'b0000, tc_q[d], 32'd0});
      n1_c[d]     = 53'sd3 * t3e_c[d] - 53'sd6 * t2s_c[d] + (53'sd1 <<< 50);
      n2_c[d]     = 53'sd3 * t2s_c[d] + 53'sd3 * t32_c[d] + (53'sd1 <<< 48)
                    - 53'sd3 * t3e_c[d];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < 2; d++) begin
      span_q[d] <= span_c[d];
      t_q[d]    <= 17'(scaled_c[d] - {span_c[d], 16'd0});
      tb_q[d]   <= t_q[d];
      t2_q[d]   <= 34'(t_q[d]) * 34'(t_q[d]);
      m2_q[d]   <= 34'(ONE - t_q[d]) * 34'(ONE - t_q[d]);
      tc_q[d]   <= tb_q[d];
      t2c_q[d]  <= t2_q[d];
      t3_q[d]   <= 51'(t2_q[d]) * 51'(tb_q[d]);
      m3_q[d]   <= 51'(m2_q[d]) * 51'(ONE - tb_q[d]);
      // round half up, then divide by three: (n + 3*2^32) / (6*2^32)
      n_q[d][0] <= 19'((53'(m3_q[d]) + (53'd3 << 32)) >> 33);
      n_q[d][1] <= 19'((n1_c[d] + (53'sd3 <<< 32)) >>> 33);
      n_q[d][2] <= 19'((n2_c[d] + (53'sd3 <<< 32)) >>> 33);
      n_q[d][3] <= 19'((t3e_c[d] + (53'sd3 <<< 32)) >>> 33);
      for (int k = 0; k < 4; k++) begin
        b_q[d][k] <= 17'((40'(n_q[d][k]) * 40'(RECIP3)) >> 22);
      end
    end
  end

  assign wsel   = cfg_i.rational ? $signed(rd_q[31:0]) : 32'sd65536;
  assign vsum_c = (66'(pa_q) <<< 16) + $signed({17'd0, pb_q}) + 66'sd2147483648;

  always_ff @(posedge clk_i) begin
    prod_q   <= 33'(34'(b_q[0][ta]) * 34'(b_q[1][tc]));
    pa_q     <= 50'($signed({1'b0, prod_q})) * 50'($signed(wsel[31:16]));
    pb_q     <= 49'(prod_q) * 49'(wsel[15:0]);
    c2_q[0]  <= $signed(rd_q[127:96]);
    c2_q[1]  <= $signed(rd_q[95:64]);
    c2_q[2]  <= $signed(rd_q[63:32]);
    coeff_q  <= vsum_c[65:32];
    coeff4_q <= coeff_q;
    for (int k = 0; k < 3; k++) begin
      c3_q[k] <= c2_q[k];
      ph_q[k] <= 50'(coeff_q) * 50'($signed(c3_q[k][31:16]));
      pl_q[k] <= 51'(coeff_q) * $signed({35'd0, c3_q[k][15:0]});
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    rbs_divider u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (div_start),
      .num_i   (acc_q[k]),
      .den_i   (den_q),
      .busy_o  (div_busy[k]),
      .res_o   (div_res[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bcnt_q      <= '0;
      tap_q       <= '0;
      {v1_q, v2_q, v3_q, v4_q} <= '0;
      {l1_q, l2_q, l3_q, l4_q} <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= issue;
      l1_q <= issue && (tap_q == 5'd15);
      v2_q <= v1_q;
      l2_q <= l1_q;
      v3_q <= v2_q;
      l3_q <= l2_q;
      v4_q <= v3_q;
      l4_q <= l3_q;
      if (issue) tap_q <= tap_q + 1'b1;
      if (emit_go) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            case (q_entry_i.kind)
              KIND_EVAL: begin
                bcnt_q  <= '0;
                state_q <= S_BASIS;
              end
              KIND_NULL: state_q <= S_EMIT;
              default: ;
            endcase
          end
        end
        S_BASIS: begin
          bcnt_q <= bcnt_q + 1'b1;
          if (bcnt_q == 3'd4) begin
            tap_q   <= '0;
            state_q <= S_TAPS;
          end
        end
        S_TAPS: begin
          if (v4_q && l4_q) state_q <= S_CHECK;
        end
        S_CHECK: state_q <= (den_q != '0) ? S_DIV : S_EMIT;
        S_DIV: begin
          if (div_busy == '0) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      u_q <= q_entry_i.u;
      v_q <= q_entry_i.v;
      res_ok_q <= 1'b0;
      for (int k = 0; k < 3; k++) res_q[k] <= '0;
    end
    if (state_q == S_BASIS) begin
      den_q <= '0;
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
    end else if (v4_q) begin
      den_q <= den_q + 64'(coeff4_q);
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= acc_q[k] + (64'(ph_q[k]) <<< 16) + 64'(pl_q[k]);
      end
    end
    if ((state_q == S_DIV) && (div_busy == '0)) begin
      res_ok_q <= 1'b1;
      for (int k = 0; k < 3; k++) res_q[k] <= $signed(div_res[k]);
    end
    if (emit_go) begin
      out_ok_q <= res_ok_q;
      for (int k = 0; k < 3; k++) out_q[k] <= res_q[k];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign surf_x_o      = out_q[0];
  assign surf_y_o      = out_q[1];
  assign surf_z_o      = out_q[2];
  assign point_valid_o = out_ok_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == S_IDLE) else $error("queue popped while busy");
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> den_q != '0) else $error("divide started on zero denominator");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT)) else $error("result without emit");
  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TAPS |-> tap_q <= 5'd16) else $error("tap counter overrun");
  a_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && l4_q) |-> state_q == S_TAPS) else $error("tap drained outside tap phase");
`endif

endmodule

// File: rtl/core/rational_bspline_surface_eval.sv
// Load word: written to the grid store when the idle back end pops it from the queue, no result.
// Evaluate word: a basis phase, then 16 grid reads at one per cycle through a 5-stage
// multiply-accumulate, then a 64-step radix-2 divider.
// Grid under 4x4 answers without evaluating, zero denominator answers without a divide.
// The back end takes a new word only when idle; a 2-word queue keeps accepting meanwhile.
// Reset clears control state and sets grid 4x4, non-rational; grid store is not cleared.
module rational_bspline_surface_eval import rbs_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [3:0]         row_i,
  input  logic [3:0]         col_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] point_weight_i,
  input  logic [16:0]        u_param_i,
  input  logic [16:0]        v_param_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] surf_x_o,
  output logic signed [31:0] surf_y_o,
  output logic signed [31:0] surf_z_o,
  output logic               point_valid_o
);

  logic   q_push, q_full, q_pop, q_valid;
  entry_t q_in, q_out;
  cfg_t   cfg;

  rbs_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .point_weight_i (point_weight_i),
    .u_param_i      (u_param_i),
    .v_param_i      (v_param_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_in),
    .cfg_o          (cfg)
  );

  rbs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  rbs_back #(.MAX_DIM(MAX_DIM)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_out),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .surf_x_o      (surf_x_o),
    .surf_y_o      (surf_y_o),
    .surf_z_o      (surf_z_o),
    .point_valid_o (point_valid_o)
  );

endmodule
